[hw/rtl/vgd_pkg.sv]
// Shared constants and types for the voxel grid downsampler.
// No dependencies.
`default_nettype none
package vgd_pkg;
    localparam int EDGE_W   = 23;
    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = 2;
    localparam logic [EDGE_W-1:0] EDGE_RESET = 23'd256;

    // classification of a queued point transaction
    typedef struct packed {
        logic keep;     // stored (store not full)
        logic last_pt;  // closes the set
    } vgd_tag_t;
endpackage
`default_nettype wire

[hw/rtl/vgd_div.sv]
// Three-lane restoring divider, one quotient bit per cycle, signed dividend.
// Depends on nothing but its parameters.
`default_nettype none
module vgd_div #(
    parameter int SUM_W      = 35,
    parameter int CNT_W      = 11,
    parameter int COORD_BITS = 24
) (
    input  wire                          clk,
    input  wire                          rstn,
    input  wire                          start,
    input  wire  signed [SUM_W-1:0]      sum_x,
    input  wire  signed [SUM_W-1:0]      sum_y,
    input  wire  signed [SUM_W-1:0]      sum_z,
    input  wire         [CNT_W-1:0]      cnt,
    output logic                         done,
    output logic        [COORD_BITS-1:0] quo_x,
    output logic        [COORD_BITS-1:0] quo_y,
    output logic        [COORD_BITS-1:0] quo_z
);
    localparam int STEP_W = $clog2(SUM_W + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      rem_reg [3];
    logic [SUM_W-1:0]      mag_reg [3];
    logic                  neg_reg [3];
    logic signed [SUM_W-1:0] sum_in [3];
    logic [CNT_W:0]        shifted [3];
    logic                  qbit [3];
    logic [SUM_W-1:0]      quo_full [3];

    assign sum_in[0] = sum_x;
    assign sum_in[1] = sum_y;
    assign sum_in[2] = sum_z;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            shifted[a] = {rem_reg[a], mag_reg[a][SUM_W-1]};
            qbit[a]    = (shifted[a] >= {1'b0, cnt_reg});
            quo_full[a] = neg_reg[a] ? (~mag_reg[a] + SUM_W'(1)) : mag_reg[a];
        end
    end

    assign quo_x = quo_full[0][COORD_BITS-1:0];
    assign quo_y = quo_full[1][COORD_BITS-1:0];
    assign quo_z = quo_full[2][COORD_BITS-1:0];
    assign done  = done_reg;

    always_ff @(posedge clk) begin
        if (!rstn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
            cnt_reg  <= cnt;
            for (int a = 0; a < 3; a++) begin
                neg_reg[a] <= sum_in[a][SUM_W-1];
                mag_reg[a] <= sum_in[a][SUM_W-1] ? (~sum_in[a] + SUM_W'(1)) : sum_in[a];
                rem_reg[a] <= '0;
            end
        end else if (busy_reg) begin
            for (int a = 0; a < 3; a++) begin
                rem_reg[a] <= qbit[a] ? CNT_W'(shifted[a] - {1'b0, cnt_reg})
                                      : shifted[a][CNT_W-1:0];
                mag_reg[a] <= {mag_reg[a][SUM_W-2:0], qbit[a]};
            end
            step_reg <= step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(SUM_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

[hw/rtl/vgd_front.sv]
// Front end: takes point transactions, assigns store slots, queues them.
// Depends on vgd_pkg.
`default_nettype none
module vgd_front #(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 24
) (
    input  wire                        clk,
    input  wire                        rstn,
    input  wire                        hold_off,
    input  wire                        s_valid,
    output logic                       s_ready,
    input  wire  [COORD_BITS-1:0]      s_x,
    input  wire  [COORD_BITS-1:0]      s_y,
    input  wire  [COORD_BITS-1:0]      s_z,
    input  wire                        s_last,
    output logic                       q_valid,
    input  wire                        q_pop,
    output logic [COORD_BITS-1:0]      q_x,
    output logic [COORD_BITS-1:0]      q_y,
    output logic [COORD_BITS-1:0]      q_z,
    output logic [((MAX_POINTS>1)?$clog2(MAX_POINTS):1)-1:0] q_idx,
    output vgd_pkg::vgd_tag_t          q_tag
);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int PI_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int PW    = vgd_pkg::Q_PTR_W;

    logic [COORD_BITS-1:0] qx_reg [vgd_pkg::Q_DEPTH];
    logic [COORD_BITS-1:0] qy_reg [vgd_pkg::Q_DEPTH];
    logic [COORD_BITS-1:0] qz_reg [vgd_pkg::Q_DEPTH];
    logic [PI_W-1:0]       qi_reg [vgd_pkg::Q_DEPTH];
    vgd_pkg::vgd_tag_t     qt_reg [vgd_pkg::Q_DEPTH];
    logic [PW-1:0]         wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]           count_reg;
    logic [CNT_W-1:0]      held_reg;
    logic                  push;
    logic                  keep;

    assign s_ready = (count_reg != (PW+1)'(vgd_pkg::Q_DEPTH)) && !hold_off;
    assign push    = s_valid && s_ready;
    assign keep    = (held_reg < CNT_W'(MAX_POINTS));
    assign q_valid = (count_reg != '0);
    assign q_x     = qx_reg[rd_ptr_reg];
    assign q_y     = qy_reg[rd_ptr_reg];
    assign q_z     = qz_reg[rd_ptr_reg];
    assign q_idx   = qi_reg[rd_ptr_reg];
    assign q_tag   = qt_reg[rd_ptr_reg];

    always_ff @(posedge clk) begin
        if (push) begin
            qx_reg[wr_ptr_reg] <= s_x;
            qy_reg[wr_ptr_reg] <= s_y;
            qz_reg[wr_ptr_reg] <= s_z;
            qi_reg[wr_ptr_reg] <= held_reg[PI_W-1:0];
            qt_reg[wr_ptr_reg] <= '{keep: keep, last_pt: s_last};
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            held_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
                if (s_last) begin
                    held_reg <= '0;
                end else if (keep) begin
                    held_reg <= held_reg + CNT_W'(1);
                end
            end
            if (q_pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (push && !q_pop) begin
                count_reg <= count_reg + (PW+1)'(1);
            end else if (!push && q_pop) begin
                count_reg <= count_reg - (PW+1)'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rstn)
        count_reg <= (PW+1)'(vgd_pkg::Q_DEPTH))
        else $error("queue overfilled");
endmodule
`default_nettype wire

[hw/rtl/vgd_back.sv]
// Back end: point store, extent tracking, grid sizing, binning, cell scan, output.
// Depends on vgd_pkg and vgd_div.
`default_nettype none
module vgd_back #(
    parameter int MAX_POINTS     = 1024,
    parameter int CELLS_PER_AXIS = 4,
    parameter int COORD_BITS     = 24
) (
    input  wire                               clk,
    input  wire                               rstn,
    input  wire  [vgd_pkg::EDGE_W-1:0]        edge_len,
    input  wire                               q_valid,
    output logic                              q_pop,
    input  wire  [COORD_BITS-1:0]             q_x,
    input  wire  [COORD_BITS-1:0]             q_y,
    input  wire  [COORD_BITS-1:0]             q_z,
    input  wire  [((MAX_POINTS>1)?$clog2(MAX_POINTS):1)-1:0] q_idx,
    input  vgd_pkg::vgd_tag_t                 q_tag,
    output logic                              clearing,
    output logic                              m_valid,
    input  wire                               m_ready,
    output logic [COORD_BITS-1:0]             m_cx,
    output logic [COORD_BITS-1:0]             m_cy,
    output logic [COORD_BITS-1:0]             m_cz,
    output logic [$clog2(MAX_POINTS+1)-1:0]   m_members,
    output logic                              m_clipped,
    output logic                              m_last
);
    localparam int EW     = vgd_pkg::EDGE_W;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int PI_W   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int BIN_W  = (CELLS_PER_AXIS > 1) ? $clog2(CELLS_PER_AXIS) : 1;
    localparam int NW     = $clog2(CELLS_PER_AXIS + 1);
    localparam int CA_W   = 3 * BIN_W;
    localparam int CDEPTH = 1 << CA_W;
    localparam int SUM_W  = COORD_BITS + CNT_W;
    localparam int ACC_W  = EW + NW;
    localparam int CMP_W  = (ACC_W > COORD_BITS) ? ACC_W : COORD_BITS;
    localparam int CELL_W = CNT_W + 3 * SUM_W;
    localparam int PT_W   = 3 * COORD_BITS;
    localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    typedef enum logic [13:0] {
        S_CLR  = 14'b00000000000001,
        S_LOAD = 14'b00000000000010,
        S_SPAN = 14'b00000000000100,
        S_GRID = 14'b00000000001000,
        S_PRD  = 14'b00000000010000,
        S_POFF = 14'b00000000100000,
        S_PBIN = 14'b00000001000000,
        S_CRD  = 14'b00000010000000,
        S_CWR  = 14'b00000100000000,
        S_SRD  = 14'b00001000000000,
        S_SCHK = 14'b00010000000000,
        S_SDIV = 14'b00100000000000,
        S_SPUT = 14'b01000000000000,
        S_SEND = 14'b10000000000000
    } vgd_state_t;

    vgd_state_t state_reg;

    logic [PT_W-1:0]   pstore [MAX_POINTS];
    logic [PT_W-1:0]   prd_reg;
    logic [CELL_W-1:0] cmem [CDEPTH];
    logic [CELL_W-1:0] crd_reg;

    logic [CA_W-1:0]   clr_addr_reg;
    logic [CNT_W-1:0]  nheld_reg;
    logic [PI_W-1:0]   pidx_reg;
    logic signed [COORD_BITS-1:0] lo_reg [3];
    logic signed [COORD_BITS-1:0] hi_reg [3];
    logic signed [COORD_BITS-1:0] pt_reg [3];
    logic [COORD_BITS-1:0] span_reg [3];
    logic [COORD_BITS-1:0] off_reg [3];
    logic [NW-1:0]     n_reg [3];
    logic              found_reg [3];
    logic [BIN_W-1:0]  bin_reg [3];
    logic [BIN_W-1:0]  scan_reg [3];
    logic [NW-1:0]     k_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic              clip_reg;

    logic              hold_valid_reg;
    logic [COORD_BITS-1:0] hold_x_reg, hold_y_reg, hold_z_reg;
    logic [CNT_W-1:0]  hold_n_reg;
    logic [CNT_W-1:0]  mem_n_reg;

    logic              out_valid_reg;
    logic [COORD_BITS-1:0] out_x_reg, out_y_reg, out_z_reg;
    logic [CNT_W-1:0]  out_n_reg;
    logic              out_clip_reg, out_last_reg;

    logic [ACC_W-1:0]  edge_eff;
    logic signed [COORD_BITS-1:0] qc [3];
    logic signed [COORD_BITS-1:0] pc [3];
    logic              hit_span [3];
    logic              hit_off [3];
    logic              grid_clip, bin_clip;
    logic              last_k;
    logic              last_pt;
    logic [CNT_W-1:0]  cell_cnt;
    logic              out_free;
    logic              can_put;
    logic              out_load;
    logic              end_z, end_y, end_x;
    logic              div_start, div_done;
    logic [COORD_BITS-1:0] dq_x, dq_y, dq_z;
    logic [CA_W-1:0]   bin_addr, scan_addr;

    assign edge_eff = (edge_len == '0) ? ACC_W'(1) : ACC_W'(edge_len);
    assign qc[0] = q_x;
    assign qc[1] = q_y;
    assign qc[2] = q_z;
    assign pc[0] = prd_reg[PT_W-1 -: COORD_BITS];
    assign pc[1] = prd_reg[2*COORD_BITS-1 -: COORD_BITS];
    assign pc[2] = prd_reg[COORD_BITS-1:0];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            hit_span[a] = (CMP_W'(acc_reg) >= CMP_W'(span_reg[a]));
            hit_off[a]  = (CMP_W'(off_reg[a]) >= CMP_W'(acc_reg));
        end
    end

    always_comb begin
        grid_clip = 1'b0;
        bin_clip  = 1'b0;
        for (int a = 0; a < 3; a++) begin
            if (!found_reg[a] && !hit_span[a] && last_k) begin
                grid_clip = 1'b1;
            end
            if (hit_off[a] && (k_reg == n_reg[a])) begin
                bin_clip = 1'b1;
            end
        end
    end

    assign last_k    = (k_reg == NW'(CELLS_PER_AXIS));
    assign last_pt   = ((CNT_W'(pidx_reg) + CNT_W'(1)) == nheld_reg);
    assign cell_cnt  = crd_reg[CELL_W-1 -: CNT_W];
    assign out_free  = !out_valid_reg || m_ready;
    assign can_put   = !hold_valid_reg || out_free;
    assign out_load  = ((state_reg == S_SPUT) && can_put && hold_valid_reg)
                       || ((state_reg == S_SEND) && out_free);
    assign end_z     = (scan_reg[2] == BIN_W'(n_reg[2] - NW'(1)));
    assign end_y     = (scan_reg[1] == BIN_W'(n_reg[1] - NW'(1)));
    assign end_x     = (scan_reg[0] == BIN_W'(n_reg[0] - NW'(1)));
    assign bin_addr  = {bin_reg[0], bin_reg[1], bin_reg[2]};
    assign scan_addr = {scan_reg[0], scan_reg[1], scan_reg[2]};
    assign div_start = (state_reg == S_SCHK) && (cell_cnt != '0);
    assign q_pop     = (state_reg == S_LOAD) && q_valid;
    assign clearing  = (state_reg == S_CLR);

    assign m_valid   = out_valid_reg;
    assign m_cx      = out_x_reg;
    assign m_cy      = out_y_reg;
    assign m_cz      = out_z_reg;
    assign m_members = out_n_reg;
    assign m_clipped = out_clip_reg;
    assign m_last    = out_last_reg;

    vgd_div #(
        .SUM_W      (SUM_W),
        .CNT_W      (CNT_W),
        .COORD_BITS (COORD_BITS)
    ) u_div (
        .clk   (clk),
        .rstn  (rstn),
        .start (div_start),
        .sum_x (crd_reg[3*SUM_W-1 -: SUM_W]),
        .sum_y (crd_reg[2*SUM_W-1 -: SUM_W]),
        .sum_z (crd_reg[SUM_W-1:0]),
        .cnt   (cell_cnt),
        .done  (div_done),
        .quo_x (dq_x),
        .quo_y (dq_y),
        .quo_z (dq_z)
    );

    // point store
    always_ff @(posedge clk) begin
        if (q_pop && q_tag.keep) begin
            pstore[q_idx] <= {q_x, q_y, q_z};
        end
        if (state_reg == S_PRD) begin
            prd_reg <= pstore[pidx_reg];
        end
    end

    // cell store: read-before-write, scanned cells cleared as read
    always_ff @(posedge clk) begin
        if (state_reg == S_CRD) begin
            crd_reg <= cmem[bin_addr];
        end else if (state_reg == S_SRD) begin
            crd_reg <= cmem[scan_addr];
        end
        if (state_reg == S_CLR) begin
            cmem[clr_addr_reg] <= '0;
        end else if (state_reg == S_SRD) begin
            cmem[scan_addr] <= '0;
        end else if (state_reg == S_CWR) begin
            cmem[bin_addr] <= {
                cell_cnt + CNT_W'(1),
                crd_reg[3*SUM_W-1 -: SUM_W] + {{CNT_W{pt_reg[0][COORD_BITS-1]}}, pt_reg[0]},
                crd_reg[2*SUM_W-1 -: SUM_W] + {{CNT_W{pt_reg[1][COORD_BITS-1]}}, pt_reg[1]},
                crd_reg[SUM_W-1:0]          + {{CNT_W{pt_reg[2][COORD_BITS-1]}}, pt_reg[2]}
            };
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            state_reg      <= S_CLR;
            clr_addr_reg   <= '0;
            nheld_reg      <= '0;
            clip_reg       <= 1'b0;
            hold_valid_reg <= 1'b0;
            for (int a = 0; a < 3; a++) begin
                lo_reg[a] <= CMAX;
                hi_reg[a] <= CMIN;
            end
        end else begin
            unique case (state_reg)
                S_CLR: begin
                    clr_addr_reg <= clr_addr_reg + CA_W'(1);
                    if (clr_addr_reg == '1) begin
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (q_valid) begin
                        if (q_tag.keep) begin
                            nheld_reg <= CNT_W'(q_idx) + CNT_W'(1);
                            for (int a = 0; a < 3; a++) begin
                                if (qc[a] < lo_reg[a]) lo_reg[a] <= qc[a];
                                if (qc[a] > hi_reg[a]) hi_reg[a] <= qc[a];
                            end
                        end
                        if (q_tag.last_pt) begin
                            state_reg <= S_SPAN;
                        end
                    end
                end
                S_SPAN: begin
                    for (int a = 0; a < 3; a++) begin
                        span_reg[a]  <= (hi_reg[a] > lo_reg[a]) ?
                                        COORD_BITS'(hi_reg[a] - lo_reg[a]) : '0;
                        found_reg[a] <= 1'b0;
                    end
                    k_reg     <= NW'(1);
                    acc_reg   <= edge_eff;
                    state_reg <= S_GRID;
                end
                S_GRID: begin
                    for (int a = 0; a < 3; a++) begin
                        if (!found_reg[a] && hit_span[a]) begin
                            n_reg[a]     <= k_reg;
                            found_reg[a] <= 1'b1;
                        end else if (!found_reg[a] && last_k) begin
                            n_reg[a] <= NW'(CELLS_PER_AXIS);
                        end
                    end
                    if (grid_clip) begin
                        clip_reg <= 1'b1;
                    end
                    k_reg   <= k_reg + NW'(1);
                    acc_reg <= acc_reg + edge_eff;
                    if (last_k) begin
                        pidx_reg  <= '0;
                        state_reg <= S_PRD;
                    end
                end
                S_PRD: begin
                    state_reg <= S_POFF;
                end
                S_POFF: begin
                    for (int a = 0; a < 3; a++) begin
                        pt_reg[a]  <= pc[a];
                        off_reg[a] <= (pc[a] > lo_reg[a]) ? COORD_BITS'(pc[a] - lo_reg[a]) : '0;
                        bin_reg[a] <= '0;
                    end
                    k_reg     <= NW'(1);
                    acc_reg   <= edge_eff;
                    state_reg <= S_PBIN;
                end
                S_PBIN: begin
                    for (int a = 0; a < 3; a++) begin
                        if (hit_off[a] && (k_reg < n_reg[a])) begin
                            bin_reg[a] <= bin_reg[a] + BIN_W'(1);
                        end
                    end
                    if (bin_clip) begin
                        clip_reg <= 1'b1;
                    end
                    k_reg   <= k_reg + NW'(1);
                    acc_reg <= acc_reg + edge_eff;
                    if (last_k) begin
                        state_reg <= S_CRD;
                    end
                end
                S_CRD: begin
                    state_reg <= S_CWR;
                end
                S_CWR: begin
                    pidx_reg <= pidx_reg + PI_W'(1);
                    if (last_pt) begin
                        for (int a = 0; a < 3; a++) begin
                            scan_reg[a] <= '0;
                        end
                        state_reg <= S_SRD;
                    end else begin
                        state_reg <= S_PRD;
                    end
                end
                S_SRD: begin
                    state_reg <= S_SCHK;
                end
                S_SCHK: begin
                    mem_n_reg <= cell_cnt;
                    if (cell_cnt != '0) begin
                        state_reg <= S_SDIV;
                    end else if (end_x && end_y && end_z) begin
                        state_reg <= S_SEND;
                    end else begin
                        state_reg <= S_SRD;
                    end
                    if (cell_cnt == '0) begin
                        scan_reg[2] <= end_z ? '0 : scan_reg[2] + BIN_W'(1);
                        if (end_z) scan_reg[1] <= end_y ? '0 : scan_reg[1] + BIN_W'(1);
                        if (end_z && end_y) scan_reg[0] <= scan_reg[0] + BIN_W'(1);
                    end
                end
                S_SDIV: begin
                    if (div_done) begin
                        state_reg <= S_SPUT;
                    end
                end
                S_SPUT: begin
                    if (can_put) begin
                        if (hold_valid_reg) begin
                            out_x_reg     <= hold_x_reg;
                            out_y_reg     <= hold_y_reg;
                            out_z_reg     <= hold_z_reg;
                            out_n_reg     <= hold_n_reg;
                            out_clip_reg  <= clip_reg;
                            out_last_reg  <= 1'b0;
                        end
                        hold_valid_reg <= 1'b1;
                        hold_x_reg     <= dq_x;
                        hold_y_reg     <= dq_y;
                        hold_z_reg     <= dq_z;
                        hold_n_reg     <= mem_n_reg;
                        scan_reg[2] <= end_z ? '0 : scan_reg[2] + BIN_W'(1);
                        if (end_z) scan_reg[1] <= end_y ? '0 : scan_reg[1] + BIN_W'(1);
                        if (end_z && end_y) scan_reg[0] <= scan_reg[0] + BIN_W'(1);
                        state_reg <= (end_x && end_y && end_z) ? S_SEND : S_SRD;
                    end
                end
                S_SEND: begin
                    if (out_free) begin
                        out_x_reg      <= hold_x_reg;
                        out_y_reg      <= hold_y_reg;
                        out_z_reg      <= hold_z_reg;
                        out_n_reg      <= hold_n_reg;
                        out_clip_reg   <= clip_reg;
                        out_last_reg   <= 1'b1;
                        hold_valid_reg <= 1'b0;
                        nheld_reg      <= '0;
                        clip_reg       <= 1'b0;
                        for (int a = 0; a < 3; a++) begin
                            lo_reg[a] <= CMAX;
                            hi_reg[a] <= CMIN;
                        end
                        state_reg <= S_LOAD;
                    end
                end
                default: begin
                    state_reg <= S_CLR;
                end
            endcase
        end
    end

    a_bin_in_grid: assert property (@(posedge clk) disable iff (!rstn)
        (state_reg == S_CRD) |-> ((NW'(bin_reg[0]) < n_reg[0]) && (NW'(bin_reg[1]) < n_reg[1])
                                  && (NW'(bin_reg[2]) < n_reg[2])))
        else $error("bin index outside grid");

    a_send_has_result: assert property (@(posedge clk) disable iff (!rstn)
        (state_reg == S_SEND) |-> hold_valid_reg)
        else $error("set closed with no pending result");

    a_no_load_while_busy: assert property (@(posedge clk) disable iff (!rstn)
        q_pop |-> (state_reg == S_LOAD))
        else $error("queue popped outside load");
endmodule
`default_nettype wire

[hw/rtl/voxel_grid_downsample.sv]
// Voxel grid downsampler: points load at one per cycle while the back end is loading and
// the front queue of 4 is not full (the back pops a queued point whenever it is loading).
// On the final point the back sizes the grid, then for each stored point reads, offsets,
// bins and updates its cell, then scans each grid cell (read and check), passing each
// non-empty cell through the divider, and closes the set. After reset the cell memory is
// swept with input ready low; synchronous active-low reset, voxel edge resets to 256.
`default_nettype none
module voxel_grid_downsample #(
    parameter int MAX_POINTS     = 1024,
    parameter int CELLS_PER_AXIS = 4,
    parameter int COORD_BITS     = 24
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cfg_wr_en,
    input  wire  [vgd_pkg::EDGE_W-1:0]       cfg_wr_data,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire  [COORD_BITS-1:0]            s_point_x,
    input  wire  [COORD_BITS-1:0]            s_point_y,
    input  wire  [COORD_BITS-1:0]            s_point_z,
    input  wire                              s_final_point,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [COORD_BITS-1:0]            m_centroid_x,
    output logic [COORD_BITS-1:0]            m_centroid_y,
    output logic [COORD_BITS-1:0]            m_centroid_z,
    output logic [$clog2(MAX_POINTS+1)-1:0]  m_members,
    output logic                             m_clipped,
    output logic                             m_last_cell
);
    localparam int PI_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    logic [vgd_pkg::EDGE_W-1:0] edge_reg;
    logic                  clearing;
    logic                  q_valid, q_pop;
    logic [COORD_BITS-1:0] q_x, q_y, q_z;
    logic [PI_W-1:0]       q_idx;
    vgd_pkg::vgd_tag_t     q_tag;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_reg <= vgd_pkg::EDGE_RESET;
        end else if (cfg_wr_en) begin
            edge_reg <= cfg_wr_data;
        end
    end

    vgd_front #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk      (aclk),
        .rstn     (aresetn),
        .hold_off (clearing),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_x      (s_point_x),
        .s_y      (s_point_y),
        .s_z      (s_point_z),
        .s_last   (s_final_point),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_x      (q_x),
        .q_y      (q_y),
        .q_z      (q_z),
        .q_idx    (q_idx),
        .q_tag    (q_tag)
    );

    vgd_back #(
        .MAX_POINTS     (MAX_POINTS),
        .CELLS_PER_AXIS (CELLS_PER_AXIS),
        .COORD_BITS     (COORD_BITS)
    ) u_back (
        .clk       (aclk),
        .rstn      (aresetn),
        .edge_len  (edge_reg),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_x       (q_x),
        .q_y       (q_y),
        .q_z       (q_z),
        .q_idx     (q_idx),
        .q_tag     (q_tag),
        .clearing  (clearing),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_cx      (m_centroid_x),
        .m_cy      (m_centroid_y),
        .m_cz      (m_centroid_z),
        .m_members (m_members),
        .m_clipped (m_clipped),
        .m_last    (m_last_cell)
    );
endmodule
`default_nettype wire

[dv/tb_voxel_grid_downsample.sv]
// Testbench for voxel_grid_downsample: drives point sets, predicts voxel centroids.
// Depends on vgd_pkg and voxel_grid_downsample; self-contained otherwise.
`timescale 1ns / 1ps
`default_nettype none
module tb_voxel_grid_downsample;
    localparam int NPTS   = 1024;
    localparam int CPA    = 4;
    localparam int CW     = 24;
    localparam int EW     = vgd_pkg::EDGE_W;
    localparam int MW     = $clog2(NPTS + 1);
    localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
    localparam longint CMIN = -CMAX - 1;

    typedef struct {
        logic [CW-1:0] cx;
        logic [CW-1:0] cy;
        logic [CW-1:0] cz;
        logic [MW-1:0] members;
        logic          clipped;
        logic          last_cell;
    } centroid_t;

    class centroid_scoreboard;
        int            errors;
        logic [EW-1:0] edge_reg;
        longint        px[$];
        longint        py[$];
        longint        pz[$];
        longint        lo[3];
        longint        hi[3];
        bit            clip;
        centroid_t     expected_q[$];

        function new();
            errors = 0;
            edge_reg = vgd_pkg::EDGE_RESET;
            clear_set();
        endfunction

        function void clear_set();
            px.delete(); py.delete(); pz.delete();
            foreach (lo[a]) begin
                lo[a] = CMAX;
                hi[a] = CMIN;
            end
            clip = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function longint axis_cells(longint l, longint h, longint e);
            longint span;
            longint n;
            span = (h > l) ? h - l : 0;
            n = (span + e - 1) / e;
            if (n == 0) n = 1;
            if (n > CPA) begin
                n = CPA;
                clip = 1;
            end
            return n;
        endfunction

        function longint bin_index(longint p, longint l, longint e, longint n);
            longint b;
            b = ((p > l) ? p - l : 0) / e;
            if (b >= n) begin
                b = n - 1;
                clip = 1;
            end
            return b;
        endfunction

        function void note_point(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z,
                                 logic fin);
            longint v[3];
            longint e, nx, ny, nz, c;
            int     cnt[CPA*CPA*CPA];
            longint sx[CPA*CPA*CPA];
            longint sy[CPA*CPA*CPA];
            longint sz[CPA*CPA*CPA];
            centroid_t r;
            int     lastpos;
            v[0] = longint'($signed(x));
            v[1] = longint'($signed(y));
            v[2] = longint'($signed(z));
            if (px.size() < NPTS) begin
                px.insert(px.size(), v[0]);
                py.insert(py.size(), v[1]);
                pz.insert(pz.size(), v[2]);
                foreach (v[a]) begin
                    if (v[a] < lo[a]) lo[a] = v[a];
                    if (v[a] > hi[a]) hi[a] = v[a];
                end
            end
            if (!fin) return;
            e  = (edge_reg != 0) ? longint'(edge_reg) : 1;
            nx = axis_cells(lo[0], hi[0], e);
            ny = axis_cells(lo[1], hi[1], e);
            nz = axis_cells(lo[2], hi[2], e);
            foreach (cnt[k]) begin
                cnt[k] = 0; sx[k] = 0; sy[k] = 0; sz[k] = 0;
            end
            foreach (px[i]) begin
                c = bin_index(px[i], lo[0], e, nx) + bin_index(py[i], lo[1], e, ny) * nx
                    + bin_index(pz[i], lo[2], e, nz) * nx * ny;
                cnt[c]++;
                sx[c] += px[i]; sy[c] += py[i]; sz[c] += pz[i];
            end
            lastpos = -1;
            for (longint ix = 0; ix < nx; ix++)
                for (longint iy = 0; iy < ny; iy++)
                    for (longint iz = 0; iz < nz; iz++) begin
                        c = ix + iy * nx + iz * nx * ny;
                        if (cnt[c] == 0) continue;
                        r.cx = CW'(sx[c] / cnt[c]);
                        r.cy = CW'(sy[c] / cnt[c]);
                        r.cz = CW'(sz[c] / cnt[c]);
                        r.members = MW'(cnt[c]);
                        r.clipped = clip;
                        r.last_cell = 0;
                        expected_q.insert(expected_q.size(), r);
                        lastpos = expected_q.size() - 1;
                    end
            if (lastpos >= 0) expected_q[lastpos].last_cell = 1;
            clear_set();
        endfunction

        task report(string what, longint got, longint want);
            $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
            errors++;
        endtask

        task check_result(centroid_t got);
            centroid_t w;
            if (expected_q.size() == 0) begin
                report("unexpected transaction", 0, 0);
                return;
            end
            w = expected_q.pop_front();
            if (got.cx !== w.cx) report("centroid_x", got.cx, w.cx);
            if (got.cy !== w.cy) report("centroid_y", got.cy, w.cy);
            if (got.cz !== w.cz) report("centroid_z", got.cz, w.cz);
            if (got.members !== w.members) report("members", got.members, w.members);
            if (got.clipped !== w.clipped) report("clipped", got.clipped, w.clipped);
            if (got.last_cell !== w.last_cell) report("last_cell", got.last_cell, w.last_cell);
        endtask
    endclass

    logic              aclk = 0;
    logic              aresetn = 0;
    logic              cfg_wr_en = 0;
    logic [EW-1:0]     cfg_wr_data = '0;
    logic              s_valid = 0;
    logic              s_ready;
    logic [CW-1:0]     s_point_x = '0;
    logic [CW-1:0]     s_point_y = '0;
    logic [CW-1:0]     s_point_z = '0;
    logic              s_final_point = 0;
    logic              m_valid;
    logic              m_ready = 0;
    logic [CW-1:0]     m_centroid_x;
    logic [CW-1:0]     m_centroid_y;
    logic [CW-1:0]     m_centroid_z;
    logic [MW-1:0]     m_members;
    logic              m_clipped;
    logic              m_last_cell;

    centroid_scoreboard sb = new();

    voxel_grid_downsample #(
        .MAX_POINTS(NPTS), .CELLS_PER_AXIS(CPA), .COORD_BITS(CW)
    ) dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_point_x(s_point_x), .s_point_y(s_point_y), .s_point_z(s_point_z),
        .s_final_point(s_final_point),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_centroid_x(m_centroid_x), .m_centroid_y(m_centroid_y),
        .m_centroid_z(m_centroid_z), .m_members(m_members),
        .m_clipped(m_clipped), .m_last_cell(m_last_cell)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int idle_cycles();
        // roughly a third of transactions go back to back
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 17);
    endfunction

    function automatic logic [CW-1:0] clamp_coord(longint v);
        if (v > CMAX) v = CMAX;
        if (v < CMIN) v = CMIN;
        return CW'(v);
    endfunction

    task automatic send_point(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z,
                              logic fin);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_point_x <= x;
        s_point_y <= y;
        s_point_z <= z;
        s_final_point <= fin;
        do @(posedge aclk); while (!s_ready);
        sb.note_point(x, y, z, fin);
    endtask

    task automatic write_edge(logic [EW-1:0] value);
        s_valid <= 0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        cfg_wr_en <= 1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 0;
        sb.edge_reg = value;
    endtask

    // set of n points clustered around a random base, spread of a few voxels, or over the full range when wide
    task automatic send_set(int n, bit wide);
        longint base[3];
        longint spread;
        logic [CW-1:0] c[3];
        foreach (base[a]) base[a] = longint'($signed(CW'($urandom)));
        spread = longint'((sb.edge_reg == 0) ? 1 : sb.edge_reg) * $urandom_range(0, 5)
                 + $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
            foreach (c[a]) begin
                if (wide) c[a] = CW'($urandom);
                else c[a] = clamp_coord(base[a] + longint'($urandom_range(0, 32'(spread))));
            end
            send_point(c[0], c[1], c[2], i == n - 1);
        end
    endtask

    initial begin
        centroid_t got;
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            stall = idle_cycles();
            if (stall > 0) begin
                m_ready <= 0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1;
            do @(posedge aclk); while (!m_valid);
            got.cx = m_centroid_x;
            got.cy = m_centroid_y;
            got.cz = m_centroid_z;
            got.members = m_members;
            got.clipped = m_clipped;
            got.last_cell = m_last_cell;
            sb.check_result(got);
        end
    end

    initial begin
        int sent;
        int n;
        int waited;
        logic [EW-1:0] edges[5];
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // single point, zero extent
        send_point(24'h000100, 24'h7FFFFF, 24'h800000, 1);
        // full-range extremes, grid clamp
        send_point(24'h800000, 24'h800000, 24'h800000, 0);
        send_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 0);
        send_point(24'hFFFFFF, 24'h000000, 24'h555555, 1);
        // span an exact multiple of the edge: index equals cell count
        send_point(24'h000000, 24'h000000, 24'hFFFF00, 0);
        send_point(24'h000200, 24'h000100, 24'h000000, 0);
        send_point(24'h000100, 24'h000200, 24'hFFFF00, 1);
        // negative sums truncate toward zero
        send_point(24'hFFFFFF, 24'hFFFFFE, 24'h000001, 0);
        send_point(24'hFFFFFE, 24'hFFFFFF, 24'h000002, 1);

        write_edge(23'd0);
        send_point(24'h000000, 24'h000001, 24'h000002, 0);
        send_point(24'h000003, 24'h000003, 24'h000002, 1);
        write_edge(23'h7FFFFF);
        send_point(24'h800000, 24'h000000, 24'h000000, 0);
        send_point(24'h7FFFFF, 24'h000000, 24'h000000, 1);
        write_edge(23'd1);
        send_set(6, 0);

        edges = '{23'd1, 23'h7FFFFF, 23'd0, vgd_pkg::EDGE_RESET, 23'd64};
        sent = 0;
        while (sent < 140) begin
            if ($urandom_range(0, 3) == 0) begin
                if ($urandom_range(0, 1) == 0) write_edge(edges[$urandom_range(0, 4)]);
                else write_edge(EW'($urandom_range(2, 100000)));
            end
            n = $urandom_range(1, 12);
            send_set(n, $urandom_range(0, 4) == 0);
            sent += n;
        end
        s_valid <= 0;

        waited = 0;
        while (sb.pending() != 0 && waited < 500000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (3000) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
`default_nettype wire

[voxel_grid_downsample.f]
hw/rtl/vgd_pkg.sv
hw/rtl/vgd_div.sv
hw/rtl/vgd_front.sv
hw/rtl/vgd_back.sv
hw/rtl/voxel_grid_downsample.sv
dv/tb_voxel_grid_downsample.sv
